/* design/fdm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the floppy drive mechanism.
package fdm_pkg;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned CYL_W  = 7;
  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  typedef enum logic [1:0] {
    OP_PORT_WRITE = 2'd0,
    OP_STATUS     = 2'd1,
    OP_INSERT     = 2'd2,
    OP_EJECT      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    DT_35_DD  = 2'd0,
    DT_35_HD  = 2'd1,
    DT_525_DD = 2'd2
  } drive_type_e;

  typedef enum logic [2:0] {
    REG_DRIVE_NUMBER  = 3'd0,
    REG_DRIVE_TYPE    = 3'd1,
    REG_START_DELAY   = 3'd2,
    REG_STOP_DELAY    = 3'd3,
    REG_STEP_DELAY    = 3'd4,
    REG_REVERSE_DELAY = 3'd5
  } cfg_reg_e;

  // Identification patterns, shifted out MSB first
  localparam logic [31:0] ID_INTERNAL = 32'h0000_0000;
  localparam logic [31:0] ID_DD       = 32'hFFFF_FFFF;
  localparam logic [31:0] ID_HD_DISK  = 32'hAAAA_AAAA;
  localparam logic [31:0] ID_525      = 32'h5555_5555;

  // Status bits are active low
  localparam logic [7:0] STAT_IDLE    = 8'hFF;
  localparam logic [7:0] STAT_READY   = 8'b1101_1111;
  localparam logic [7:0] STAT_TRACK0  = 8'b1110_1111;
  localparam logic [7:0] STAT_PROTECT = 8'b1111_0111;
  localparam logic [7:0] STAT_CHANGE  = 8'b1111_1011;

  // Cylinder sequences a host produces while polling an empty drive
  localparam logic [31:0] POLL_SIG0 = 32'h0100_0100;
  localparam logic [31:0] POLL_SIG1 = 32'h0001_0001;
  localparam logic [31:0] POLL_SIG2 = 32'h0203_0203;
  localparam logic [31:0] POLL_SIG3 = 32'h0302_0302;

  // Port bit positions
  localparam int unsigned PB_STEP = 0;
  localparam int unsigned PB_DIR  = 1;
  localparam int unsigned PB_SIDE = 2;
  localparam int unsigned PB_SEL0 = 3;
  localparam int unsigned PB_MTR  = 7;

  typedef struct packed {
    logic [1:0]  drive_number;
    drive_type_e drive_type;
    logic [31:0] start_delay;
    logic [31:0] stop_delay;
    logic [31:0] step_pulse_delay;
    logic [31:0] reverse_step_delay;
  } fdm_cfg_t;

  typedef struct packed {
    op_e               operation;
    logic [TIME_W-1:0] now_cycle;
    logic [7:0]        port_value;
    logic              disk_is_35;
    logic              disk_is_hd;
    logic              disk_write_protected;
  } fdm_item_t;

  typedef struct packed {
    logic [7:0]       status_flags;
    logic [CYL_W-1:0] head_cylinder;
    logic             head_side;
    logic             motor_on;
    logic             polling_seen;
    logic             insert_accepted;
  } fdm_result_t;

endpackage

/* design/fdm_in_if.sv */
`timescale 1ns / 1ps
// Input item channel: valid/ready with the item fields.
interface fdm_in_if import fdm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [TIME_W-1:0] now_cycle;
  logic [7:0]        port_value;
  logic              disk_is_35;
  logic              disk_is_hd;
  logic              disk_write_protected;

  modport source (
    output valid, operation, now_cycle, port_value, disk_is_35, disk_is_hd,
           disk_write_protected,
    input  ready
  );
  modport sink (
    input  valid, operation, now_cycle, port_value, disk_is_35, disk_is_hd,
           disk_write_protected,
    output ready
  );
endinterface

/* design/fdm_out_if.sv */
`timescale 1ns / 1ps
// Result channel: valid/ready with the result fields.
interface fdm_out_if import fdm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [7:0]       status_flags;
  logic [CYL_W-1:0] head_cylinder;
  logic             head_side;
  logic             motor_on;
  logic             polling_seen;
  logic             insert_accepted;

  modport source (
    output valid, status_flags, head_cylinder, head_side, motor_on, polling_seen,
           insert_accepted,
    input  ready
  );
  modport sink (
    input  valid, status_flags, head_cylinder, head_side, motor_on, polling_seen,
           insert_accepted,
    output ready
  );
endinterface

/* design/fdm_cfg.sv */
`timescale 1ns / 1ps
// APB configuration registers of the drive.
module fdm_cfg import fdm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output fdm_cfg_t          cfg_o
);

  fdm_cfg_t cfg_q, cfg_d;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = cfg_reg_e'(paddr[CFG_AW-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_DRIVE_NUMBER:  cfg_d.drive_number       = pwdata[1:0];
        REG_DRIVE_TYPE:    cfg_d.drive_type         = drive_type_e'(pwdata[1:0]);
        REG_START_DELAY:   cfg_d.start_delay        = pwdata;
        REG_STOP_DELAY:    cfg_d.stop_delay         = pwdata;
        REG_STEP_DELAY:    cfg_d.step_pulse_delay   = pwdata;
        REG_REVERSE_DELAY: cfg_d.reverse_step_delay = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DRIVE_NUMBER:  prdata = {30'b0, cfg_q.drive_number};
      REG_DRIVE_TYPE:    prdata = {30'b0, cfg_q.drive_type};
      REG_START_DELAY:   prdata = cfg_q.start_delay;
      REG_STOP_DELAY:    prdata = cfg_q.stop_delay;
      REG_STEP_DELAY:    prdata = cfg_q.step_pulse_delay;
      REG_REVERSE_DELAY: prdata = cfg_q.reverse_step_delay;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* design/fdm_core.sv */
`timescale 1ns / 1ps
// Drive state and the update that one item applies to it, computed combinationally and registered on fire_i.
module fdm_core import fdm_pkg::*; #(
  parameter int unsigned MAX_CYLINDER = 83,
  parameter int unsigned TIME_BITS    = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  fdm_item_t   item_i,
  input  fdm_cfg_t    cfg_i,
  output fdm_result_t res_o
);

  localparam logic [CYL_W-1:0] MaxCyl = CYL_W'(MAX_CYLINDER);

  logic                 motor_q, motor_d;
  logic                 fs_q, fs_d;
  logic [TIME_BITS-1:0] switch_time_q, switch_time_d;
  logic [4:0]           id_cnt_q, id_cnt_d;
  logic                 id_bit_q, id_bit_d;
  logic [7:0]           port_q, port_d;
  logic [CYL_W-1:0]     cyl_q, cyl_d;
  logic                 side_q, side_d;
  logic                 chg_q, chg_d;
  logic                 present_q, present_d;
  logic                 hd_q, hd_d;
  logic                 prot_q, prot_d;
  logic [TIME_BITS-1:0] step_t_q, step_t_d;
  logic [TIME_BITS-1:0] up_t_q, up_t_d;
  logic [TIME_BITS-1:0] dn_t_q, dn_t_d;
  logic [31:0]          hist_q, hist_d;

  logic [63:0]          now_ext;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] el_sw, el_step, el_up, el_dn;
  logic                 fs_now;
  logic [2:0]           sel_idx;
  logic                 old_sel;
  logic                 new_sel;
  logic [31:0]          id_word;
  logic [4:0]           cnt_inc;
  logic                 motor_req;
  logic                 switched;
  logic                 accepted;
  logic                 fs_after;
  logic [7:0]           status;

  assign now_ext = 64'(item_i.now_cycle);
  assign now_t   = now_ext[TIME_BITS-1:0];
  assign el_sw   = now_t - switch_time_q;
  assign el_step = now_t - step_t_q;
  assign el_up   = now_t - up_t_q;
  assign el_dn   = now_t - dn_t_q;

  // Motor at full speed at this item's time, before the item acts
  always_comb begin
    if (motor_q) begin
      fs_now = (cfg_i.start_delay == '0) || fs_q ||
               (64'(el_sw) >= 64'(cfg_i.start_delay));
    end else begin
      fs_now = (cfg_i.stop_delay != '0) && fs_q &&
               (64'(el_sw) < 64'(cfg_i.stop_delay));
    end
  end

  assign sel_idx = 3'(cfg_i.drive_number) + 3'(PB_SEL0);
  assign old_sel = port_q[sel_idx];
  assign new_sel = item_i.port_value[sel_idx];
  assign cnt_inc = id_cnt_q + 5'd1;

  always_comb begin
    if (cfg_i.drive_number == 2'd0) begin
      id_word = ID_INTERNAL;
    end else begin
      case (cfg_i.drive_type)
        DT_35_HD:  id_word = (present_q && hd_q) ? ID_HD_DISK : ID_DD;
        DT_525_DD: id_word = ID_525;
        default:   id_word = ID_DD;
      endcase
    end
  end

  always_comb begin
    motor_d       = motor_q;
    fs_d          = fs_q;
    switch_time_d = switch_time_q;
    id_cnt_d      = id_cnt_q;
    id_bit_d      = id_bit_q;
    port_d        = port_q;
    cyl_d         = cyl_q;
    side_d        = side_q;
    chg_d         = chg_q;
    present_d     = present_q;
    hd_d          = hd_q;
    prot_d        = prot_q;
    step_t_d      = step_t_q;
    up_t_d        = up_t_q;
    dn_t_d        = dn_t_q;
    hist_d        = hist_q;
    motor_req     = 1'b0;
    switched      = 1'b0;
    accepted      = 1'b0;

    case (item_i.operation)
      OP_PORT_WRITE: begin
        port_d = item_i.port_value;
        // select falling edge clocks the id shifter and the motor latch
        if (old_sel && !new_sel) begin
          id_cnt_d  = cnt_inc;
          id_bit_d  = id_word[~cnt_inc];
          motor_req = !port_q[PB_MTR] || !item_i.port_value[PB_MTR];
          if (motor_q != motor_req) begin
            switched      = 1'b1;
            fs_d          = fs_now;
            switch_time_d = now_t;
            motor_d       = motor_req;
            id_cnt_d      = '0;
          end
        end
        if (!port_q[PB_STEP] && item_i.port_value[PB_STEP] && !old_sel) begin
          if (present_q) begin
            chg_d = 1'b1;
          end
          if (64'(el_step) >= 64'(cfg_i.step_pulse_delay)) begin
            if (item_i.port_value[PB_DIR]) begin
              if ((64'(el_up) >= 64'(cfg_i.reverse_step_delay)) && (cyl_q != '0)) begin
                cyl_d    = cyl_q - CYL_W'(1);
                hist_d   = {hist_q[23:0], 1'b0, cyl_d};
                step_t_d = now_t;
                dn_t_d   = now_t;
              end
            end else begin
              if ((64'(el_dn) >= 64'(cfg_i.reverse_step_delay)) && (cyl_q < MaxCyl)) begin
                cyl_d    = cyl_q + CYL_W'(1);
                hist_d   = {hist_q[23:0], 1'b0, cyl_d};
                step_t_d = now_t;
                up_t_d   = now_t;
              end
            end
          end
        end
        side_d = !item_i.port_value[PB_SIDE];
      end
      OP_INSERT: begin
        case (cfg_i.drive_type)
          DT_35_DD:  accepted = item_i.disk_is_35 && !item_i.disk_is_hd;
          DT_35_HD:  accepted = item_i.disk_is_35;
          DT_525_DD: accepted = !item_i.disk_is_35 && !item_i.disk_is_hd;
          default:   accepted = 1'b0;
        endcase
        if (accepted) begin
          if (present_q) begin
            chg_d = 1'b0;
          end
          present_d = 1'b1;
          hd_d      = item_i.disk_is_hd;
          prot_d    = item_i.disk_write_protected;
        end
      end
      OP_EJECT: begin
        if (present_q) begin
          chg_d     = 1'b0;
          present_d = 1'b0;
          hd_d      = 1'b0;
          prot_d    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // After a switch the elapsed time is zero, so only the delays matter
  always_comb begin
    if (switched) begin
      fs_after = motor_d ? ((cfg_i.start_delay == '0) || fs_now)
                         : ((cfg_i.stop_delay != '0) && fs_now);
    end else begin
      fs_after = fs_now;
    end
  end

  always_comb begin
    status = STAT_IDLE;
    if (!port_d[sel_idx]) begin
      if (fs_after ? present_d : id_bit_d) begin
        status = status & STAT_READY;
      end
      if (cyl_d == '0) begin
        status = status & STAT_TRACK0;
      end
      if (!(present_d && !prot_d)) begin
        status = status & STAT_PROTECT;
      end
      if (!chg_d) begin
        status = status & STAT_CHANGE;
      end
    end
  end

  assign res_o.status_flags    = status;
  assign res_o.head_cylinder   = cyl_d;
  assign res_o.head_side       = side_d;
  assign res_o.motor_on        = motor_d;
  assign res_o.polling_seen    = !present_d &&
                                 ((hist_d == POLL_SIG0) || (hist_d == POLL_SIG1) ||
                                  (hist_d == POLL_SIG2) || (hist_d == POLL_SIG3));
  assign res_o.insert_accepted = accepted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_q       <= 1'b0;
      fs_q          <= 1'b0;
      switch_time_q <= '0;
      id_cnt_q      <= '0;
      id_bit_q      <= 1'b0;
      port_q        <= '0;
      cyl_q         <= '0;
      side_q        <= 1'b0;
      chg_q         <= 1'b0;
      present_q     <= 1'b0;
      hd_q          <= 1'b0;
      prot_q        <= 1'b0;
      step_t_q      <= '0;
      up_t_q        <= '0;
      dn_t_q        <= '0;
      hist_q        <= '0;
    end else if (fire_i) begin
      motor_q       <= motor_d;
      fs_q          <= fs_d;
      switch_time_q <= switch_time_d;
      id_cnt_q      <= id_cnt_d;
      id_bit_q      <= id_bit_d;
      port_q        <= port_d;
      cyl_q         <= cyl_d;
      side_q        <= side_d;
      chg_q         <= chg_d;
      present_q     <= present_d;
      hd_q          <= hd_d;
      prot_q        <= prot_d;
      step_t_q      <= step_t_d;
      up_t_q        <= up_t_d;
      dn_t_q        <= dn_t_d;
      hist_q        <= hist_d;
    end
  end

endmodule

/* design/floppy_drive_mechanism_top.sv */
`timescale 1ns / 1ps
// Floppy drive mechanism: each item passes the input register, then the result register.
// Throughput one item per cycle while the result side does not stall; the drive state
// updates combinationally in fdm_core, between the input and result registers.
// A stalled result lets one more item into the input register, then in_i.ready drops.
// rst_ni (async, active low) clears drive state, configuration and valid flags.
module floppy_drive_mechanism_top import fdm_pkg::*; #(
  parameter int unsigned MAX_CYLINDER = 83,
  parameter int unsigned TIME_BITS    = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fdm_in_if.sink            in_i,
  fdm_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam logic [CYL_W-1:0] MaxCyl = CYL_W'(MAX_CYLINDER);

  fdm_cfg_t    cfg;
  fdm_item_t   item_q;
  fdm_result_t res_d, res_q;
  logic        in_valid_q;
  logic        out_valid_q;
  logic        adv;
  logic        in_xfer;

  fdm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fdm_core #(
    .MAX_CYLINDER (MAX_CYLINDER),
    .TIME_BITS    (TIME_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  assign adv        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.operation            <= op_e'(in_i.operation);
      item_q.now_cycle            <= in_i.now_cycle;
      item_q.port_value           <= in_i.port_value;
      item_q.disk_is_35           <= in_i.disk_is_35;
      item_q.disk_is_hd           <= in_i.disk_is_hd;
      item_q.disk_write_protected <= in_i.disk_write_protected;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status_flags    = res_q.status_flags;
  assign out_o.head_cylinder   = res_q.head_cylinder;
  assign out_o.head_side       = res_q.head_side;
  assign out_o.motor_on        = res_q.motor_on;
  assign out_o.polling_seen    = res_q.polling_seen;
  assign out_o.insert_accepted = res_q.insert_accepted;

  // a held item is never dropped while the result side stalls
  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q)
    else $error("pending item lost");

  // every item that leaves the input register shows up as a result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("result not presented");

  a_cyl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.head_cylinder <= MaxCyl)
    else $error("head beyond last cylinder");

endmodule
